// ----- rtl/core/buddy_page_allocator_macros.svh -----
// ----------------------------------------------------------------------------
// buddy_page_allocator_macros
// Assertion macros used by the buddy page allocator top level.
// ----------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_MACROS_SVH

// Clocked check, masked while reset is held.
`define BPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define BPA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/bpa_pkg.sv -----
// ----------------------------------------------------------------------------
// bpa_pkg
// Types, codes and helper functions of the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int POOL_ORD_MAX_DEF = 10;

  localparam int CNT_W  = 11;
  localparam int IDX_W  = 10;
  localparam int BORD_W = 4;
  localparam int STAT_W = 2;
  localparam int CFG_W  = 11;
  localparam int PADDR_W = 3;

  localparam logic [1:0] MARK_NONE  = 2'd0;
  localparam logic [1:0] MARK_FREE  = 2'd1;
  localparam logic [1:0] MARK_ALLOC = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_COUNT = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_ALLOC = 2'd3;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_INIT,
    DP_CLR,
    DP_LOAD,
    DP_READ,
    DP_SCAN,
    DP_HEAD,
    DP_ULK_WR,
    DP_DOWN,
    DP_PUSH_A,
    DP_PUSH_B,
    DP_ALLOC,
    DP_FREE_GO,
    DP_MERGE,
    DP_DONE
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic              alt;
    logic [STAT_W-1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic op_free;
    logic zero_cnt;
    logic no_space;
    logic bad_idx;
    logic info_alloc;
    logic info_ord_k;
    logic buddy_free;
    logic scan_hit;
    logic scan_last;
    logic split_more;
    logic below_top;
    logic clr_done;
  } dp_stat_t;

  // Position of the highest set bit; zero maps to zero.
  function automatic logic [BORD_W-1:0] floor_log2(input logic [CNT_W-1:0] v);
    logic [BORD_W-1:0] r;
    r = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (v[i]) r = BORD_W'(i);
    end
    return r;
  endfunction

  // Smallest order whose block holds the count.
  function automatic logic [BORD_W-1:0] ceil_order(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] m;
    m = c - CNT_W'(1);
    if (c <= CNT_W'(1)) return '0;
    return floor_log2(m) + BORD_W'(1);
  endfunction

endpackage

// ----- rtl/core/bpa_datapath.sv -----
// ----------------------------------------------------------------------------
// bpa_datapath
// Page tables, free list links, list heads and counters of the allocator.
// ----------------------------------------------------------------------------
module bpa_datapath #(
  parameter int POOL_ORD_MAX = bpa_pkg::POOL_ORD_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bpa_pkg::dp_cmd_t            cmd,
  output bpa_pkg::dp_stat_t           stat,
  input  logic [bpa_pkg::CFG_W-1:0]   pool_pages,
  input  logic                        in_op,
  input  logic [bpa_pkg::CNT_W-1:0]   in_page_count,
  input  logic [bpa_pkg::IDX_W-1:0]   in_page_index,
  output logic                        out_valid,
  output logic [bpa_pkg::STAT_W-1:0]  out_status,
  output logic [bpa_pkg::IDX_W-1:0]   out_block_index,
  output logic [bpa_pkg::BORD_W-1:0]  out_block_order,
  output logic [bpa_pkg::CNT_W-1:0]   out_free_pages
);

  localparam int AW  = POOL_ORD_MAX;
  localparam int LW  = AW + 1;
  localparam int OW  = $clog2(POOL_ORD_MAX + 1);
  localparam int HN  = POOL_ORD_MAX + 1;
  localparam int NPG = 1 << AW;
  localparam int IW  = OW + 2;
  localparam logic [LW-1:0] NIL = LW'(1) << AW;

  logic [IW-1:0] info_mem [NPG];
  logic [LW-1:0] next_mem [NPG];
  logic [LW-1:0] prev_mem [NPG];
  logic [IW-1:0] info_rd_r;
  logic [LW-1:0] nx_rd_r;
  logic [LW-1:0] pv_rd_r;

  logic                     op_r;
  logic [bpa_pkg::CNT_W-1:0] cnt_r;
  logic [bpa_pkg::IDX_W-1:0] idx_r;
  logic [OW-1:0]            k_r;
  logic                     kovf_r;
  logic [OW-1:0]            ord_r;
  logic [OW-1:0]            pool_ord_r;
  logic [AW-1:0]            pg_r;
  logic [AW-1:0]            ppg_r;
  logic [LW-1:0]            h_r;
  logic [AW:0]              free_r;
  logic [LW-1:0]            heads_r [HN];
  logic [AW-1:0]            clr_r;
  logic [AW-1:0]            res_idx_r;
  logic [OW-1:0]            res_ord_r;

  logic                         out_valid_r;
  logic [bpa_pkg::STAT_W-1:0]   out_status_r;
  logic [bpa_pkg::IDX_W-1:0]    out_idx_r;
  logic [bpa_pkg::BORD_W-1:0]   out_ord_r;
  logic [bpa_pkg::CNT_W-1:0]    out_free_r;

  logic [AW-1:0]                bit_pg;
  logic [AW-1:0]                sel_pg;
  logic [LW-1:0]                head_cur;
  logic [bpa_pkg::BORD_W-1:0]   k_in;
  logic                         k_in_ovf;
  logic [bpa_pkg::BORD_W-1:0]   cfg_ord;
  logic [OW-1:0]                pool_ord_nxt;
  logic [1:0]                   rd_mark;
  logic [OW-1:0]                rd_ord;

  logic          info_we;
  logic [AW-1:0] info_wa;
  logic [IW-1:0] info_wd;
  logic          next_we;
  logic [AW-1:0] next_wa;
  logic [LW-1:0] next_wd;
  logic          prev_we;
  logic [AW-1:0] prev_wa;
  logic [LW-1:0] prev_wd;

  assign bit_pg   = AW'(1) << ord_r;
  assign sel_pg   = cmd.alt ? (pg_r ^ bit_pg) : pg_r;
  assign head_cur = heads_r[ord_r];
  assign k_in     = bpa_pkg::ceil_order(in_page_count);
  assign k_in_ovf = 32'(k_in) > POOL_ORD_MAX;
  assign cfg_ord  = bpa_pkg::floor_log2(pool_pages);
  assign pool_ord_nxt = (32'(cfg_ord) > POOL_ORD_MAX) ? OW'(POOL_ORD_MAX) : OW'(cfg_ord);
  assign rd_mark  = info_rd_r[IW-1 -: 2];
  assign rd_ord   = info_rd_r[OW-1:0];

  always_comb begin
    stat.op_free    = op_r;
    stat.zero_cnt   = (cnt_r == '0);
    stat.no_space   = (32'(cnt_r) > 32'(free_r)) || kovf_r || (k_r > pool_ord_r);
    stat.bad_idx    = 32'(idx_r) >= (32'(1) << pool_ord_r);
    stat.info_alloc = (rd_mark == bpa_pkg::MARK_ALLOC);
    stat.info_ord_k = !kovf_r && (rd_ord == k_r);
    stat.buddy_free = (rd_mark == bpa_pkg::MARK_FREE) && (rd_ord == ord_r);
    stat.scan_hit   = !head_cur[AW];
    stat.scan_last  = (ord_r == pool_ord_r);
    stat.split_more = (ord_r > k_r);
    stat.below_top  = (ord_r < pool_ord_r);
    stat.clr_done   = &clr_r;
  end

  // Write port steering for the three page stores.
  always_comb begin
    info_we = 1'b0;
    info_wa = pg_r;
    info_wd = '0;
    next_we = 1'b0;
    next_wa = sel_pg;
    next_wd = head_cur;
    prev_we = 1'b0;
    prev_wa = sel_pg;
    prev_wd = NIL;
    unique case (cmd.op)
      bpa_pkg::DP_CLR: begin
        info_we = 1'b1;
        info_wa = clr_r;
        info_wd = (clr_r == '0) ? {bpa_pkg::MARK_FREE, pool_ord_r} : '0;
        next_we = 1'b1;
        next_wa = clr_r;
        next_wd = NIL;
        prev_we = 1'b1;
        prev_wa = clr_r;
      end
      bpa_pkg::DP_PUSH_A: begin
        info_we = 1'b1;
        info_wa = sel_pg;
        info_wd = {bpa_pkg::MARK_FREE, ord_r};
        next_we = 1'b1;
        prev_we = 1'b1;
      end
      bpa_pkg::DP_PUSH_B: begin
        prev_we = !h_r[AW];
        prev_wa = h_r[AW-1:0];
        prev_wd = {1'b0, ppg_r};
      end
      bpa_pkg::DP_ULK_WR: begin
        next_we = !pv_rd_r[AW];
        next_wa = pv_rd_r[AW-1:0];
        next_wd = nx_rd_r;
        prev_we = !nx_rd_r[AW];
        prev_wa = nx_rd_r[AW-1:0];
        prev_wd = pv_rd_r;
      end
      bpa_pkg::DP_ALLOC: begin
        info_we = 1'b1;
        info_wd = {bpa_pkg::MARK_ALLOC, ord_r};
      end
      bpa_pkg::DP_MERGE: begin
        info_we = 1'b1;
        info_wa = pg_r | bit_pg;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (info_we) info_mem[info_wa] <= info_wd;
    info_rd_r <= info_mem[sel_pg];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    nx_rd_r <= next_mem[sel_pg];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    pv_rd_r <= prev_mem[sel_pg];
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      bpa_pkg::DP_INIT: begin
        pool_ord_r <= pool_ord_nxt;
        free_r     <= (AW+1)'(1) << pool_ord_nxt;
        clr_r      <= '0;
        for (int h = 0; h < HN; h++) begin
          heads_r[h] <= (h == int'(pool_ord_nxt)) ? '0 : NIL;
        end
      end
      bpa_pkg::DP_CLR: begin
        clr_r <= clr_r + AW'(1);
      end
      bpa_pkg::DP_LOAD: begin
        op_r      <= in_op;
        cnt_r     <= in_page_count;
        idx_r     <= in_page_index;
        k_r       <= OW'(k_in);
        kovf_r    <= k_in_ovf;
        ord_r     <= OW'(k_in);
        pg_r      <= AW'(in_page_index);
        res_idx_r <= '0;
        res_ord_r <= '0;
      end
      bpa_pkg::DP_SCAN: begin
        ord_r <= ord_r + OW'(1);
      end
      bpa_pkg::DP_HEAD: begin
        pg_r <= head_cur[AW-1:0];
      end
      bpa_pkg::DP_ULK_WR: begin
        // unlinking the head advances the list
        if (pv_rd_r[AW]) heads_r[ord_r] <= nx_rd_r;
      end
      bpa_pkg::DP_DOWN: begin
        ord_r <= ord_r - OW'(1);
      end
      bpa_pkg::DP_PUSH_A: begin
        h_r            <= head_cur;
        ppg_r          <= sel_pg;
        heads_r[ord_r] <= {1'b0, sel_pg};
      end
      bpa_pkg::DP_ALLOC: begin
        free_r    <= free_r - ((AW+1)'(1) << ord_r);
        res_idx_r <= pg_r;
        res_ord_r <= ord_r;
      end
      bpa_pkg::DP_FREE_GO: begin
        free_r    <= free_r + ((AW+1)'(1) << k_r);
        res_ord_r <= k_r;
      end
      bpa_pkg::DP_MERGE: begin
        pg_r  <= pg_r & ~bit_pg;
        ord_r <= ord_r + OW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.op == bpa_pkg::DP_DONE);
    end
    if (cmd.op == bpa_pkg::DP_DONE) begin
      out_status_r <= cmd.status;
      out_idx_r    <= bpa_pkg::IDX_W'(res_idx_r);
      out_ord_r    <= bpa_pkg::BORD_W'(res_ord_r);
      out_free_r   <= bpa_pkg::CNT_W'(free_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_block_index = out_idx_r;
  assign out_block_order = out_ord_r;
  assign out_free_pages  = out_free_r;

endmodule

// ----- rtl/core/bpa_ctrl.sv -----
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer for pool set-up, allocate with splits and free with merges.
// ----------------------------------------------------------------------------
module bpa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              init_req,
  input  bpa_pkg::dp_stat_t stat,
  output bpa_pkg::dp_cmd_t  cmd,
  output logic              busy
);

  typedef enum logic [4:0] {
    S_INIT, S_CLR, S_IDLE, S_CHECK, S_SCAN, S_SPLIT,
    S_SPL_RD, S_SPL_WR, S_SPL_DOWN, S_SPL_PU_A, S_SPL_PU_B, S_SPL_PL_A, S_SPL_PL_B,
    S_TAKE_RD, S_TAKE_WR, S_TAKE_SET, S_FIN,
    S_FCHK, S_F_PU_A, S_F_PU_B, S_MCHK, S_MTEST,
    S_M_WR0, S_M_RD1, S_M_WR1, S_MERGE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd.op     = bpa_pkg::DP_NONE;
    cmd.alt    = 1'b0;
    cmd.status = bpa_pkg::ST_OK;
    unique case (state_r)
      S_INIT: begin
        cmd.op    = bpa_pkg::DP_INIT;
        state_nxt = S_CLR;
      end
      S_CLR: begin
        cmd.op = bpa_pkg::DP_CLR;
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.op    = bpa_pkg::DP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.zero_cnt) begin
          cmd.op     = bpa_pkg::DP_DONE;
          cmd.status = bpa_pkg::ST_BAD_COUNT;
          state_nxt  = S_IDLE;
        end else if (!stat.op_free) begin
          if (stat.no_space) begin
            cmd.op     = bpa_pkg::DP_DONE;
            cmd.status = bpa_pkg::ST_NO_SPACE;
            state_nxt  = S_IDLE;
          end else begin
            state_nxt = S_SCAN;
          end
        end else if (stat.bad_idx) begin
          cmd.op     = bpa_pkg::DP_DONE;
          cmd.status = bpa_pkg::ST_NOT_ALLOC;
          state_nxt  = S_IDLE;
        end else begin
          cmd.op    = bpa_pkg::DP_READ;
          state_nxt = S_FCHK;
        end
      end
      S_SCAN: begin
        if (stat.scan_hit) begin
          state_nxt = S_SPLIT;
        end else if (stat.scan_last) begin
          cmd.op     = bpa_pkg::DP_DONE;
          cmd.status = bpa_pkg::ST_NO_SPACE;
          state_nxt  = S_IDLE;
        end else begin
          cmd.op = bpa_pkg::DP_SCAN;
        end
      end
      S_SPLIT: begin
        cmd.op    = bpa_pkg::DP_HEAD;
        state_nxt = stat.split_more ? S_SPL_RD : S_TAKE_RD;
      end
      S_SPL_RD: begin
        cmd.op    = bpa_pkg::DP_READ;
        state_nxt = S_SPL_WR;
      end
      S_SPL_WR: begin
        cmd.op    = bpa_pkg::DP_ULK_WR;
        state_nxt = S_SPL_DOWN;
      end
      S_SPL_DOWN: begin
        cmd.op    = bpa_pkg::DP_DOWN;
        state_nxt = S_SPL_PU_A;
      end
      S_SPL_PU_A: begin
        // upper half goes in first so the lower half ends at the head
        cmd.op    = bpa_pkg::DP_PUSH_A;
        cmd.alt   = 1'b1;
        state_nxt = S_SPL_PU_B;
      end
      S_SPL_PU_B: begin
        cmd.op    = bpa_pkg::DP_PUSH_B;
        state_nxt = S_SPL_PL_A;
      end
      S_SPL_PL_A: begin
        cmd.op    = bpa_pkg::DP_PUSH_A;
        state_nxt = S_SPL_PL_B;
      end
      S_SPL_PL_B: begin
        cmd.op    = bpa_pkg::DP_PUSH_B;
        state_nxt = S_SPLIT;
      end
      S_TAKE_RD: begin
        cmd.op    = bpa_pkg::DP_READ;
        state_nxt = S_TAKE_WR;
      end
      S_TAKE_WR: begin
        cmd.op    = bpa_pkg::DP_ULK_WR;
        state_nxt = S_TAKE_SET;
      end
      S_TAKE_SET: begin
        cmd.op    = bpa_pkg::DP_ALLOC;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.op    = bpa_pkg::DP_DONE;
        state_nxt = S_IDLE;
      end
      S_FCHK: begin
        if (!stat.info_alloc) begin
          cmd.op     = bpa_pkg::DP_DONE;
          cmd.status = bpa_pkg::ST_NOT_ALLOC;
          state_nxt  = S_IDLE;
        end else if (!stat.info_ord_k) begin
          cmd.op     = bpa_pkg::DP_DONE;
          cmd.status = bpa_pkg::ST_BAD_COUNT;
          state_nxt  = S_IDLE;
        end else begin
          cmd.op    = bpa_pkg::DP_FREE_GO;
          state_nxt = S_F_PU_A;
        end
      end
      S_F_PU_A: begin
        cmd.op    = bpa_pkg::DP_PUSH_A;
        state_nxt = S_F_PU_B;
      end
      S_F_PU_B: begin
        cmd.op    = bpa_pkg::DP_PUSH_B;
        state_nxt = S_MCHK;
      end
      S_MCHK: begin
        if (stat.below_top) begin
          cmd.op    = bpa_pkg::DP_READ;
          cmd.alt   = 1'b1;
          state_nxt = S_MTEST;
        end else begin
          cmd.op    = bpa_pkg::DP_DONE;
          state_nxt = S_IDLE;
        end
      end
      S_MTEST: begin
        if (stat.buddy_free) begin
          cmd.op    = bpa_pkg::DP_READ;
          state_nxt = S_M_WR0;
        end else begin
          cmd.op    = bpa_pkg::DP_DONE;
          state_nxt = S_IDLE;
        end
      end
      S_M_WR0: begin
        cmd.op    = bpa_pkg::DP_ULK_WR;
        state_nxt = S_M_RD1;
      end
      S_M_RD1: begin
        cmd.op    = bpa_pkg::DP_READ;
        cmd.alt   = 1'b1;
        state_nxt = S_M_WR1;
      end
      S_M_WR1: begin
        cmd.op    = bpa_pkg::DP_ULK_WR;
        state_nxt = S_MERGE;
      end
      S_MERGE: begin
        cmd.op    = bpa_pkg::DP_MERGE;
        state_nxt = S_F_PU_A;
      end
      default: state_nxt = S_INIT;
    endcase
    // a pool size write rebuilds the store
    if (init_req) begin
      cmd.op     = bpa_pkg::DP_NONE;
      cmd.alt    = 1'b0;
      cmd.status = bpa_pkg::ST_OK;
      state_nxt  = S_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ----- rtl/core/buddy_page_allocator.sv -----
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Allocate: scans past empty orders, then splits the block found down to the
// requested order; free: merges the block with free buddies of equal order.
// One item at a time, paced by the page stores (one read, one write port).
// Reset and every pool_pages write clear all 2^POOL_ORD_MAX pages (busy high).
// ----------------------------------------------------------------------------
`include "buddy_page_allocator_macros.svh"

module buddy_page_allocator #(
  parameter int POOL_ORD_MAX = bpa_pkg::POOL_ORD_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpa_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_op,
  input  logic [bpa_pkg::CNT_W-1:0]     in_page_count,
  input  logic [bpa_pkg::IDX_W-1:0]     in_page_index,
  output logic                          out_valid,
  output logic [bpa_pkg::STAT_W-1:0]    out_status,
  output logic [bpa_pkg::IDX_W-1:0]     out_block_index,
  output logic [bpa_pkg::BORD_W-1:0]    out_block_order,
  output logic [bpa_pkg::CNT_W-1:0]     out_free_pages
);

  logic [bpa_pkg::CFG_W-1:0] pool_pages_r;
  logic                      reg_sel;
  logic                      init_req;
  bpa_pkg::dp_cmd_t          cmd;
  bpa_pkg::dp_stat_t         stat;

  assign pready   = 1'b1;
  assign reg_sel  = !paddr[2];
  assign init_req = psel && penable && pwrite && reg_sel;
  assign prdata   = reg_sel ? 32'(pool_pages_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_pages_r <= bpa_pkg::CFG_W'(1024);
    end else if (init_req) begin
      pool_pages_r <= pwdata[bpa_pkg::CFG_W-1:0];
    end
  end

  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .init_req (init_req),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  bpa_datapath #(
    .POOL_ORD_MAX (POOL_ORD_MAX)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .pool_pages      (pool_pages_r),
    .in_op           (in_op),
    .in_page_count   (in_page_count),
    .in_page_index   (in_page_index),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_block_index (out_block_index),
    .out_block_order (out_block_order),
    .out_free_pages  (out_free_pages)
  );

  `BPA_ASSERT(a_out_in_op, out_valid |-> $past(busy), "result strobe without an operation in flight")
  `BPA_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted transfer did not raise busy")
  `BPA_ASSERT(a_fail_no_block, (out_valid && out_status != bpa_pkg::ST_OK) |-> (out_block_index == '0 && out_block_order == '0), "failed operation reported a block")
  `BPA_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "result strobe right after reset")

endmodule
